/* rtl/core/eewl_pkg.sv */
// eewl_pkg: shared constants, command codes and controller types for the
// eeprom block rotator. No dependencies.
`default_nettype none

package eewl_pkg;

  // block geometry
  localparam int BLOCK_BYTES  = 32;
  localparam int BLOCK_COUNT  = 4;
  localparam int HEADER_BYTES = 4;
  localparam int DATA_BYTES   = BLOCK_BYTES - HEADER_BYTES;

  // derived widths
  localparam int BLK_W  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int DIDX_W = $clog2(DATA_BYTES);
  localparam int CNT_W  = $clog2(BLOCK_BYTES + 1);

  // fixed port widths
  localparam int CMD_W   = 3;
  localparam int OFF_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int HDR_W   = 32;
  localparam int FRAME_W = 24;
  localparam int FLEN_W  = 2;
  localparam int ACT_W   = 2;

  // generation header and microwire opcodes
  localparam logic [HDR_W-1:0]  HDR_A      = 32'hAA55AA55;
  localparam logic [BYTE_W-1:0] MW_READ    = 8'b0000_0110;
  localparam logic [BYTE_W-1:0] MW_WRITE   = 8'b0000_0010;
  localparam logic [BYTE_W-1:0] MW_EWEN    = 8'b0110_0000;
  localparam logic [BYTE_W-1:0] MW_EWDS    = 8'b0000_0000;
  localparam logic [FLEN_W-1:0] FLEN_NONE  = 2'd0;
  localparam logic [FLEN_W-1:0] FLEN_TWO   = 2'd2;
  localparam logic [FLEN_W-1:0] FLEN_THREE = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN_SCAN  = 3'd0,
    CMD_HEADER_SEEN = 3'd1,
    CMD_LOAD_BYTE   = 3'd2,
    CMD_HOST_WRITE  = 3'd3,
    CMD_HOST_READ   = 3'd4,
    CMD_FLUSH       = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FLUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic exec_one;
    logic flush_open;
    logic flush_byte;
    logic flush_close;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic flush_go;
    logic bytes_done;
  } stat_t;

  // read frame for one block: opcode, then word address shifted left
  function automatic logic [FRAME_W-1:0] read_frame(input logic [BLK_W-1:0] blk);
    logic [15:0] addr;
    addr = 16'(blk) * 16'(BLOCK_BYTES);
    return {MW_READ, addr[6:0], 1'b0, 8'h00};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/eeprom_wear_level_block_rotator.sv */
// eeprom_wear_level_block_rotator: top level of the eeprom block rotator.
// Depends on eewl_pkg, eewl_ctrl and eewl_dp.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one command request at a
//   time: begin scan, header seen, load byte, host write, host read, flush.
//   The result channel (out_valid/out_ready) returns the results of each
//   request in order; out_last marks the final one of a request.
//   A request is latched on acceptance and executed once the result
//   register is free; its results leave through the result register.
//   A flush with pending data walks the block one byte per cycle while the
//   receiver keeps up: write enable, one write per block byte, write
//   disable, 34 results in all; the input stays busy until the write
//   disable has been issued.
//   in_ready is high only while the controller is idle.
//   When the receiver stalls, the result register holds its value and the
//   sequencer waits; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) clears all flags, the block index, the
//   data buffer valid bits and the scan state; the header returns to its
//   default generation value. No clearing pass is needed.
`default_nettype none

module eeprom_wear_level_block_rotator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [eewl_pkg::CMD_W-1:0]    in_command,
  input  wire logic [eewl_pkg::OFF_W-1:0]    in_byte_offset,
  input  wire logic [eewl_pkg::BYTE_W-1:0]   in_byte_value,
  input  wire logic [eewl_pkg::HDR_W-1:0]    in_header_word,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [eewl_pkg::FRAME_W-1:0]       out_frame,
  output logic [eewl_pkg::FLEN_W-1:0]        out_frame_bytes,
  output logic                               out_last,
  output logic [eewl_pkg::BYTE_W-1:0]        out_read_value,
  output logic                               out_accepted,
  output logic                               out_status_valid,
  output logic                               out_scan_done,
  output logic [eewl_pkg::ACT_W-1:0]         out_active_block
);
  import eewl_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // sequencing
  eewl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // state, buffer and result register
  eewl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_command       (in_command),
    .in_byte_offset   (in_byte_offset),
    .in_byte_value    (in_byte_value),
    .in_header_word   (in_header_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame        (out_frame),
    .out_frame_bytes  (out_frame_bytes),
    .out_last         (out_last),
    .out_read_value   (out_read_value),
    .out_accepted     (out_accepted),
    .out_status_valid (out_status_valid),
    .out_scan_done    (out_scan_done),
    .out_active_block (out_active_block)
  );

  // a latched request blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous still executing");

  // a byte write is never the final result of a request
  a_last_not_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_frame_bytes != FLEN_THREE)
    else $error("flush ended on a byte write");

  // scan completion is a single-result request
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scan_done |-> out_last)
    else $error("scan done on a non-final result");

  // host accesses carry no frame
  a_acc_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_frame_bytes == FLEN_NONE && out_last)
    else $error("accepted host access with a frame");

endmodule

`default_nettype wire

/* rtl/core/eewl_ctrl.sv */
// eewl_ctrl: sequencing state machine of the block rotator.
// Depends on eewl_pkg; drives the datapath through ctrl_t.
`default_nettype none

module eewl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire eewl_pkg::stat_t stat,
  output eewl_pkg::ctrl_t     ctrl
);
  import eewl_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.latch = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.slot_free) begin
          if (stat.flush_go) begin
            ctrl.flush_open = 1'b1;
            state_nxt       = ST_FLUSH;
          end else begin
            ctrl.exec_one = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (stat.slot_free) begin
          if (stat.bytes_done) begin
            ctrl.flush_close = 1'b1;
            state_nxt        = ST_IDLE;
          end else begin
            ctrl.flush_byte = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/eewl_dp.sv */
// eewl_dp: request latch, rotator state, data buffer and result register.
// Depends on eewl_pkg; steered by eewl_ctrl through ctrl_t.
`default_nettype none

module eewl_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire eewl_pkg::ctrl_t               ctrl,
  output eewl_pkg::stat_t                    stat,
  input  wire logic [eewl_pkg::CMD_W-1:0]    in_command,
  input  wire logic [eewl_pkg::OFF_W-1:0]    in_byte_offset,
  input  wire logic [eewl_pkg::BYTE_W-1:0]   in_byte_value,
  input  wire logic [eewl_pkg::HDR_W-1:0]    in_header_word,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [eewl_pkg::FRAME_W-1:0]       out_frame,
  output logic [eewl_pkg::FLEN_W-1:0]        out_frame_bytes,
  output logic                               out_last,
  output logic [eewl_pkg::BYTE_W-1:0]        out_read_value,
  output logic                               out_accepted,
  output logic                               out_status_valid,
  output logic                               out_scan_done,
  output logic [eewl_pkg::ACT_W-1:0]         out_active_block
);
  import eewl_pkg::*;

  // latched request
  cmd_t              cmd_r;
  logic [OFF_W-1:0]  off_r;
  logic [BYTE_W-1:0] val_r;
  logic [HDR_W-1:0]  hdr_r;

  // rotator state
  logic              status_r, status_nxt;
  logic              pending_r, pending_nxt;
  logic [BLK_W-1:0]  idx_r, idx_nxt;
  logic [HDR_W-1:0]  gen_r, gen_nxt;
  logic [BLK_W-1:0]  scan_pos_r, scan_pos_nxt;
  logic              scanning_r, scanning_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // data buffer with per-entry valid bits
  logic [BYTE_W-1:0]     dmem_r [DATA_BYTES];
  logic [DATA_BYTES-1:0] dvalid_r;
  logic                  dclear;
  logic                  wr_en;
  logic [DIDX_W-1:0]     wr_idx;
  logic [DIDX_W-1:0]     rd_idx;
  logic [BYTE_W-1:0]     rd_byte;

  // result register
  logic               ovalid_r;
  logic [FRAME_W-1:0] oframe_r, oframe_nxt;
  logic [FLEN_W-1:0]  olen_r, olen_nxt;
  logic               olast_r, olast_nxt;
  logic [BYTE_W-1:0]  orv_r, orv_nxt;
  logic               oacc_r, oacc_nxt;
  logic               odone_r, odone_nxt;
  logic               ostat_r;
  logic [BLK_W-1:0]   oidx_r;
  logic               oload;

  logic               in_range;
  logic               go_on;
  logic [15:0]        wr_addr;
  logic [1:0]         hdr_sel;

  // request latch
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_r <= cmd_t'(in_command);
      off_r <= in_byte_offset;
      val_r <= in_byte_value;
      hdr_r <= in_header_word;
    end
  end

  assign in_range = (int'(off_r) < DATA_BYTES);
  assign oload    = ctrl.exec_one | ctrl.flush_open | ctrl.flush_byte | ctrl.flush_close;

  // status toward the controller
  assign stat.slot_free  = !ovalid_r || out_ready;
  assign stat.flush_go   = (cmd_r == CMD_FLUSH) && pending_r;
  assign stat.bytes_done = (cnt_r == CNT_W'(BLOCK_BYTES));

  // buffer read: flush walk or host read offset
  assign rd_idx  = ctrl.flush_byte ? DIDX_W'(cnt_r - CNT_W'(HEADER_BYTES))
                                   : DIDX_W'(off_r);
  assign rd_byte = dvalid_r[rd_idx] ? dmem_r[rd_idx] : '0;
  assign hdr_sel = 2'(cnt_r);
  assign wr_addr = 16'(idx_r) * 16'(BLOCK_BYTES) + 16'(cnt_r);
  assign wr_idx  = DIDX_W'(off_r);

  // command execution and flush sequencing
  always_comb begin
    status_nxt   = status_r;
    pending_nxt  = pending_r;
    idx_nxt      = idx_r;
    gen_nxt      = gen_r;
    scan_pos_nxt = scan_pos_r;
    scanning_nxt = scanning_r;
    cnt_nxt      = cnt_r;
    dclear       = 1'b0;
    wr_en        = 1'b0;
    go_on        = 1'b0;
    oframe_nxt   = '0;
    olen_nxt     = FLEN_NONE;
    olast_nxt    = 1'b0;
    orv_nxt      = '0;
    oacc_nxt     = 1'b0;
    odone_nxt    = 1'b0;

    if (ctrl.exec_one) begin
      olast_nxt = 1'b1;
      unique case (cmd_r)
        CMD_BEGIN_SCAN: begin
          dclear       = 1'b1;
          status_nxt   = 1'b0;
          pending_nxt  = 1'b0;
          idx_nxt      = '0;
          gen_nxt      = HDR_A;
          scan_pos_nxt = '0;
          scanning_nxt = 1'b1;
          oframe_nxt   = read_frame('0);
          olen_nxt     = FLEN_TWO;
        end
        CMD_HEADER_SEEN: begin
          if (scanning_r) begin
            // judge the header of the block under scan
            if (scan_pos_r == '0) begin
              idx_nxt = '0;
              if (hdr_r == HDR_A || hdr_r == ~HDR_A) begin
                gen_nxt    = hdr_r;
                status_nxt = 1'b1;
                go_on      = 1'b1;
              end else begin
                gen_nxt    = HDR_A;
                status_nxt = 1'b0;
              end
            end else if (hdr_r == gen_r) begin
              idx_nxt    = scan_pos_r;
              status_nxt = 1'b1;
              go_on      = 1'b1;
            end
            // ask for the next block or finish the scan
            if (go_on && (scan_pos_r != BLK_W'(BLOCK_COUNT - 1))) begin
              scan_pos_nxt = scan_pos_r + 1'b1;
              oframe_nxt   = read_frame(scan_pos_r + 1'b1);
              olen_nxt     = FLEN_TWO;
            end else begin
              scanning_nxt = 1'b0;
              odone_nxt    = 1'b1;
              if (status_nxt) begin
                oframe_nxt = read_frame(idx_nxt);
                olen_nxt   = FLEN_TWO;
              end
            end
          end
        end
        CMD_LOAD_BYTE: begin
          wr_en = in_range;
        end
        CMD_HOST_WRITE: begin
          wr_en    = in_range;
          oacc_nxt = in_range;
          if (in_range) begin
            pending_nxt = 1'b1;
          end
        end
        CMD_HOST_READ: begin
          if (status_r && in_range) begin
            oacc_nxt = 1'b1;
            orv_nxt  = rd_byte;
          end
        end
        CMD_FLUSH: begin
          // no pending data: lone empty result
        end
        default: begin
        end
      endcase
    end

    // flush start: rotate to the next block when one is valid, then write enable
    if (ctrl.flush_open) begin
      pending_nxt = 1'b0;
      cnt_nxt     = '0;
      if (status_r) begin
        if (idx_r == BLK_W'(BLOCK_COUNT - 1)) begin
          idx_nxt = '0;
          gen_nxt = ~gen_r;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      oframe_nxt = {MW_WRITE, MW_EWEN, 8'h00};
      olen_nxt   = FLEN_TWO;
    end

    // one byte write per cycle while the result register is free, header bytes first
    if (ctrl.flush_byte) begin
      cnt_nxt    = cnt_r + 1'b1;
      oframe_nxt = {MW_WRITE, 1'b1, wr_addr[6:0],
                    (int'(cnt_r) < HEADER_BYTES) ? gen_r[8*hdr_sel +: 8] : rd_byte};
      olen_nxt   = FLEN_THREE;
    end

    // write disable closes the flush
    if (ctrl.flush_close) begin
      oframe_nxt = {MW_WRITE, MW_EWDS, 8'h00};
      olen_nxt   = FLEN_TWO;
      olast_nxt  = 1'b1;
    end
  end

  // rotator state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r   <= 1'b0;
      pending_r  <= 1'b0;
      idx_r      <= '0;
      gen_r      <= HDR_A;
      scan_pos_r <= '0;
      scanning_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      status_r   <= status_nxt;
      pending_r  <= pending_nxt;
      idx_r      <= idx_nxt;
      gen_r      <= gen_nxt;
      scan_pos_r <= scan_pos_nxt;
      scanning_r <= scanning_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // data buffer contents
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dmem_r[wr_idx] <= val_r;
    end
  end

  // buffer valid bits, cleared by reset and begin scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r <= '0;
    end else if (dclear) begin
      dvalid_r <= '0;
    end else if (wr_en) begin
      dvalid_r[wr_idx] <= 1'b1;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (oload) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (oload) begin
      oframe_r <= oframe_nxt;
      olen_r   <= olen_nxt;
      olast_r  <= olast_nxt;
      orv_r    <= orv_nxt;
      oacc_r   <= oacc_nxt;
      odone_r  <= odone_nxt;
      ostat_r  <= status_nxt;
      oidx_r   <= idx_nxt;
    end
  end

  assign out_valid        = ovalid_r;
  assign out_frame        = oframe_r;
  assign out_frame_bytes  = olen_r;
  assign out_last         = olast_r;
  assign out_read_value   = orv_r;
  assign out_accepted     = oacc_r;
  assign out_status_valid = ostat_r;
  assign out_scan_done    = odone_r;
  assign out_active_block = ACT_W'(oidx_r);

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// tb_top: self-checking bench for the eeprom block rotator, with a shadow
// model of the block buffer, scan and flush sequencer. Depends on eewl_pkg.
// Random requests, stalls on both channels, in-order result checking.
`default_nettype none

module tb_top;
  import eewl_pkg::*;

  // spare command codes the block answers with an empty result
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam int RANDOM_REQUESTS = 120;
  localparam int HOLD_AT_REQUEST = 60;
  localparam int HOLD_CYCLES     = 300;
  localparam int CALM_TAIL       = 25;
  localparam int TAIL_CYCLES     = 40;
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [OFF_W-1:0]  byte_offset;
    logic [BYTE_W-1:0] byte_value;
    logic [HDR_W-1:0]  header_word;
    logic              wait_drain;
  } host_request_t;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic [FLEN_W-1:0]  frame_bytes;
    logic               last;
    logic [BYTE_W-1:0]  read_value;
    logic               accepted;
    logic               status_valid;
    logic               scan_done;
    logic [ACT_W-1:0]   active_block;
  } rotator_result_t;

  // dut ports
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command = '0;
  logic [OFF_W-1:0]    in_byte_offset = '0;
  logic [BYTE_W-1:0]   in_byte_value = '0;
  logic [HDR_W-1:0]    in_header_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [FRAME_W-1:0]  out_frame;
  logic [FLEN_W-1:0]   out_frame_bytes;
  logic                out_last;
  logic [BYTE_W-1:0]   out_read_value;
  logic                out_accepted;
  logic                out_status_valid;
  logic                out_scan_done;
  logic [ACT_W-1:0]    out_active_block;

  eeprom_wear_level_block_rotator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_byte_offset   (in_byte_offset),
    .in_byte_value    (in_byte_value),
    .in_header_word   (in_header_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame        (out_frame),
    .out_frame_bytes  (out_frame_bytes),
    .out_last         (out_last),
    .out_read_value   (out_read_value),
    .out_accepted     (out_accepted),
    .out_status_valid (out_status_valid),
    .out_scan_done    (out_scan_done),
    .out_active_block (out_active_block)
  );

  // request queue and expected results
  host_request_t   requests_waiting[$];
  rotator_result_t frames_due[$];

  // shadow state of the rotator
  logic [BYTE_W-1:0] shadow_buf [DATA_BYTES];
  logic              have_block;
  logic              dirty;
  logic [ACT_W-1:0]  cur_block;
  logic [HDR_W-1:0]  gen_hdr;
  logic [2:0]        probe_pos;
  logic              probing;

  int errors = 0;
  int items_taken = 0;
  int results_seen = 0;
  int flushes_written = 0;
  int header_wraps = 0;
  int scans_ended = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  logic held_once = 1'b0;
  int quiet_cycles = 0;

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [FRAME_W-1:0] block_read_cmd(input logic [ACT_W-1:0] blk);
    logic [7:0] word_addr;
    word_addr = (8'(blk) * 8'(BLOCK_BYTES)) & 8'h7F;
    return {MW_READ, word_addr[6:0], 1'b0, 8'h00};
  endfunction

  task automatic push_result(input logic [FRAME_W-1:0] frame, input logic [FLEN_W-1:0] nbytes,
                             input logic [BYTE_W-1:0] rv, input logic acc,
                             input logic done, input logic fin);
    rotator_result_t r;
    r.frame        = frame;
    r.frame_bytes  = nbytes;
    r.last         = fin;
    r.read_value   = rv;
    r.accepted     = acc;
    r.status_valid = have_block;
    r.scan_done    = done;
    r.active_block = cur_block;
    frames_due.push_back(r);
  endtask

  task automatic clear_shadow();
    foreach (shadow_buf[i]) shadow_buf[i] = '0;
    have_block = 1'b0;
    dirty      = 1'b0;
    cur_block  = '0;
    gen_hdr    = HDR_A;
    probe_pos  = '0;
  endtask

  // flush sequence: enable, header and data bytes, disable
  task automatic predict_flush();
    logic [7:0]        base;
    logic [7:0]        wr_addr;
    logic [BYTE_W-1:0] d;
    if (have_block) begin
      if (int'(cur_block) == BLOCK_COUNT - 1) begin
        cur_block = '0;
        gen_hdr   = ~gen_hdr;
        header_wraps++;
      end else begin
        cur_block = cur_block + 1'b1;
      end
    end
    base = 8'(cur_block) * 8'(BLOCK_BYTES);
    push_result({MW_WRITE, MW_EWEN, 8'h00}, FLEN_TWO, '0, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (i < HEADER_BYTES) d = gen_hdr[8*i +: 8];
      else d = shadow_buf[i - HEADER_BYTES];
      wr_addr = 8'h80 | ((base + 8'(i)) & 8'h7F);
      push_result({MW_WRITE, wr_addr, d}, FLEN_THREE, '0, 1'b0, 1'b0, 1'b0);
    end
    push_result({MW_WRITE, MW_EWDS, 8'h00}, FLEN_TWO, '0, 1'b0, 1'b0, 1'b1);
    flushes_written++;
  endtask

  // shadow model: one accepted request, its expected results queued
  task automatic apply_command(input host_request_t rq);
    logic go_on;
    logic in_range;
    in_range = int'(rq.byte_offset) < DATA_BYTES;
    go_on = 1'b0;
    case (rq.command)
      CMD_BEGIN_SCAN: begin
        clear_shadow();
        probing = 1'b1;
        push_result(block_read_cmd('0), FLEN_TWO, '0, 1'b0, 1'b0, 1'b1);
      end
      CMD_HEADER_SEEN: begin
        if (!probing) begin
          push_result('0, FLEN_NONE, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          if (probe_pos == 0) begin
            cur_block = '0;
            if (rq.header_word == HDR_A || rq.header_word == ~HDR_A) begin
              gen_hdr    = rq.header_word;
              have_block = 1'b1;
              go_on      = 1'b1;
            end else begin
              gen_hdr    = HDR_A;
              have_block = 1'b0;
            end
          end else if (rq.header_word == gen_hdr) begin
            cur_block  = probe_pos[ACT_W-1:0];
            have_block = 1'b1;
            go_on      = 1'b1;
          end
          if (go_on && int'(probe_pos) + 1 < BLOCK_COUNT) begin
            probe_pos = probe_pos + 1'b1;
            push_result(block_read_cmd(probe_pos[ACT_W-1:0]), FLEN_TWO, '0, 1'b0, 1'b0, 1'b1);
          end else begin
            probing = 1'b0;
            scans_ended++;
            if (have_block)
              push_result(block_read_cmd(cur_block), FLEN_TWO, '0, 1'b0, 1'b1, 1'b1);
            else
              push_result('0, FLEN_NONE, '0, 1'b0, 1'b1, 1'b1);
          end
        end
      end
      CMD_LOAD_BYTE: begin
        if (in_range) shadow_buf[rq.byte_offset] = rq.byte_value;
        push_result('0, FLEN_NONE, '0, 1'b0, 1'b0, 1'b1);
      end
      CMD_HOST_WRITE: begin
        if (in_range) begin
          shadow_buf[rq.byte_offset] = rq.byte_value;
          dirty = 1'b1;
        end
        push_result('0, FLEN_NONE, '0, in_range, 1'b0, 1'b1);
      end
      CMD_HOST_READ: begin
        if (have_block && in_range)
          push_result('0, FLEN_NONE, shadow_buf[rq.byte_offset], 1'b1, 1'b0, 1'b1);
        else
          push_result('0, FLEN_NONE, '0, 1'b0, 1'b0, 1'b1);
      end
      CMD_FLUSH: begin
        if (dirty) begin
          dirty = 1'b0;
          predict_flush();
        end else begin
          push_result('0, FLEN_NONE, '0, 1'b0, 1'b0, 1'b1);
        end
      end
      default: push_result('0, FLEN_NONE, '0, 1'b0, 1'b0, 1'b1);
    endcase
  endtask

  task automatic add_request(input logic [CMD_W-1:0] cmd, input logic [OFF_W-1:0] off,
                             input logic [BYTE_W-1:0] val, input logic [HDR_W-1:0] hdr,
                             input logic drain);
    host_request_t rq;
    rq.command     = cmd;
    rq.byte_offset = off;
    rq.byte_value  = val;
    rq.header_word = hdr;
    rq.wait_drain  = drain;
    requests_waiting.push_back(rq);
  endtask

  function automatic logic [OFF_W-1:0] pick_offset();
    if ($urandom_range(0, 9) == 0) return OFF_W'($urandom_range(DATA_BYTES, 31));
    return OFF_W'($urandom_range(0, DATA_BYTES - 1));
  endfunction

  // one scan followed by loads, host traffic and flushes
  task automatic add_session(inout int count);
    logic [HDR_W-1:0] first_hdr;
    logic [HDR_W-1:0] hdr;
    int n;
    int pick;
    add_request(CMD_BEGIN_SCAN, pick_offset(), 8'($urandom), $urandom,
                $urandom_range(0, 3) == 0);
    count++;
    pick = $urandom_range(0, 9);
    first_hdr = (pick < 4) ? HDR_A : (pick < 8) ? ~HDR_A : $urandom;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 7);
      if (i == 0 || pick < 6) hdr = first_hdr;
      else if (pick == 6) hdr = ~first_hdr;
      else hdr = $urandom;
      add_request(CMD_HEADER_SEEN, pick_offset(), 8'($urandom), hdr, 1'b0);
      count++;
    end
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      add_request(CMD_LOAD_BYTE, pick_offset(), 8'($urandom), $urandom, 1'b0);
      count++;
    end
    n = $urandom_range(3, 9);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9)
        add_request(CMD_HOST_WRITE, pick_offset(), 8'($urandom), $urandom, 1'b0);
      else if (pick < 17)
        add_request(CMD_HOST_READ, pick_offset(), 8'($urandom), $urandom, 1'b0);
      else
        add_request(CMD_FLUSH, pick_offset(), 8'($urandom), $urandom, 1'b0);
      count++;
    end
    if ($urandom_range(0, 9) < 7) begin
      add_request(CMD_FLUSH, pick_offset(), 8'($urandom), $urandom, 1'b0);
      count++;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    host_request_t cur;
    host_request_t nxt;
    logic fire;
    logic offer;
    fire  = in_valid && in_ready;
    offer = in_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        cur.command     = in_command;
        cur.byte_offset = in_byte_offset;
        cur.byte_value  = in_byte_value;
        cur.header_word = in_header_word;
        cur.wait_drain  = 1'b0;
        apply_command(cur);
        items_taken <= items_taken + 1;
      end
      if (!in_valid || fire) begin
        offer = 1'b0;
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (requests_waiting.size() > 0 &&
                     !(requests_waiting[0].wait_drain && frames_due.size() != 0)) begin
          if (requests_waiting.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 10);
          end else begin
            nxt = requests_waiting.pop_front();
            in_command     <= nxt.command;
            in_byte_offset <= nxt.byte_offset;
            in_byte_value  <= nxt.byte_value;
            in_header_word <= nxt.header_word;
            offer = 1'b1;
          end
        end
      end
      in_valid <= offer;
    end
  end

  // result receiver with random stalls and one long hold
  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!held_once && items_taken >= HOLD_AT_REQUEST) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (requests_waiting.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    rotator_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (frames_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual frame 0x%0h last %0b",
                 $time, out_frame, out_last);
      end else begin
        want = frames_due.pop_front();
        check_field("frame", 32'(want.frame), 32'(out_frame));
        check_field("frame_bytes", 32'(want.frame_bytes), 32'(out_frame_bytes));
        check_field("last", 32'(want.last), 32'(out_last));
        check_field("read_value", 32'(want.read_value), 32'(out_read_value));
        check_field("accepted", 32'(want.accepted), 32'(out_accepted));
        check_field("status_valid", 32'(want.status_valid), 32'(out_status_valid));
        check_field("scan_done", 32'(want.scan_done), 32'(out_scan_done));
        check_field("active_block", 32'(want.active_block), 32'(out_active_block));
      end
    end
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no request or result moved for %0d cycles, %0d results due",
               $time, quiet_cycles, frames_due.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin : run_main
    int added;
    added = 0;
    clear_shadow();
    probing = 1'b0;

    // directed: refusals before any valid block, flush paths, scan corners
    add_request(CMD_HOST_READ, 5'd0, 8'h00, 32'h0000_0000, 1'b0);
    add_request(CMD_HEADER_SEEN, 5'd31, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    add_request(CMD_FLUSH, 5'd0, 8'h00, 32'h0000_0000, 1'b0);
    add_request(CMD_HOST_WRITE, 5'd27, 8'hFF, 32'h0000_0000, 1'b0);
    add_request(CMD_HOST_WRITE, 5'd28, 8'h11, 32'h0000_0000, 1'b0);
    add_request(CMD_HOST_WRITE, 5'd31, 8'h00, 32'h0000_0000, 1'b0);
    add_request(CMD_FLUSH, 5'd0, 8'h00, 32'h0000_0000, 1'b0);
    add_request(CMD_SPARE_6, 5'd31, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    add_request(CMD_SPARE_7, 5'd0, 8'h00, 32'h0000_0000, 1'b0);
    add_request(CMD_BEGIN_SCAN, 5'd0, 8'h00, 32'h0000_0000, 1'b1);
    add_request(CMD_BEGIN_SCAN, 5'd0, 8'h00, 32'h0000_0000, 1'b0);
    add_request(CMD_HEADER_SEEN, 5'd0, 8'h00, 32'h0000_0000, 1'b0);
    add_request(CMD_HOST_READ, 5'd27, 8'h00, 32'h0000_0000, 1'b0);
    add_request(CMD_BEGIN_SCAN, 5'd0, 8'h00, 32'h0000_0000, 1'b0);
    for (int i = 0; i < BLOCK_COUNT; i++)
      add_request(CMD_HEADER_SEEN, 5'd0, 8'h00, HDR_A, 1'b0);
    add_request(CMD_LOAD_BYTE, 5'd0, 8'hA5, 32'h0000_0000, 1'b0);
    add_request(CMD_LOAD_BYTE, 5'd31, 8'h5A, 32'h0000_0000, 1'b0);
    add_request(CMD_HOST_READ, 5'd0, 8'h00, 32'h0000_0000, 1'b0);
    add_request(CMD_HOST_READ, 5'd28, 8'h00, 32'h0000_0000, 1'b0);
    add_request(CMD_HOST_WRITE, 5'd1, 8'h3C, 32'h0000_0000, 1'b0);
    // active block is the last one, so this flush wraps and inverts
    add_request(CMD_FLUSH, 5'd0, 8'h00, 32'h0000_0000, 1'b0);
    add_request(CMD_BEGIN_SCAN, 5'd0, 8'h00, 32'h0000_0000, 1'b1);
    add_request(CMD_HEADER_SEEN, 5'd0, 8'h00, ~HDR_A, 1'b0);
    add_request(CMD_HEADER_SEEN, 5'd0, 8'h00, HDR_A, 1'b0);

    // random: mostly well-formed sessions, some noise
    while (added < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 99) < 15) begin
        add_request(CMD_W'($urandom_range(0, 7)), OFF_W'($urandom_range(0, 31)),
                    8'($urandom), $urandom, $urandom_range(0, 9) == 0);
        added++;
      end else begin
        add_session(added);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_waiting.size() != 0 || in_valid || frames_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (frames_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, frames_due.size());
    end

    $display("covered %0d requests and %0d results: %0d block flushes, %0d header wraps,",
             items_taken, results_seen, flushes_written, header_wraps);
    $display("%0d finished scans, with stalls on both channels; %0d mismatches",
             scans_ended, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
